>>> sv/clut_texel_to_rgba_top_assert.svh
// Assertion macros for the concurrent checks in the top module.
`ifndef CLUT_TEXEL_TO_RGBA_TOP_ASSERT_SVH
`define CLUT_TEXEL_TO_RGBA_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define CLTTR_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("clttr check failed");

// The consequent must hold in the cycle after the antecedent.
`define CLTTR_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("clttr next-cycle check failed");

`endif

>>> sv/clttr_pkg.sv
package clttr_pkg;

    localparam int IDX_W  = 8;
    localparam int WORD_W = 16;

    typedef enum logic [1:0] {
        MODE_4BPP  = 2'd0,
        MODE_8BPP  = 2'd1,
        MODE_SOLID = 2'd2
    } t_texel_mode;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_LOOKUP,
        OP_ZERO,
        OP_WHITE
    } t_op;

    localparam logic CFG_IDX_MODE = 1'b0;
    localparam logic CFG_IDX_SEMI = 1'b1;

    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
    localparam logic [7:0] ALPHA_SEMI   = 8'd63;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  addr;
        logic [WORD_W-1:0] word;
        logic              last;
    } t_qent;

    // c * 255 / 31 equals 8c + floor(7c / 31); the second term is at most seven.
    function automatic logic [7:0] f_expand5(input logic [4:0] c);
        logic [7:0] t;
        logic [2:0] q;
        t = 8'(c) * 8'd7;
        q = '0;
        for (int k = 1; k < 8; k++) begin
            if (t >= 8'(31 * k)) begin
                q = q + 3'd1;
            end
        end
        return {c, 3'b000} + {5'b00000, q};
    endfunction

endpackage

>>> sv/clttr_ram.sv
module clttr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/clttr_front.sv
module clttr_front #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [31:0]         s_axis_tdata,
    input  logic                s_axis_tuser,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [1:0]          i_cfg_wdata,
    output logic                o_semi_on,
    output logic                o_push,
    output clttr_pkg::t_qent    o_push_ent,
    input  logic                i_q_ready
);

    import clttr_pkg::*;

    t_texel_mode r_texel_mode;
    logic        r_semi_on;
    logic        r_hold;
    logic        n_hold;
    logic [3:0]  r_hold_addr;

    logic             accept;
    logic [IDX_W-1:0] in_idx;
    logic [WORD_W-1:0] in_word;
    logic [7:0]       in_byte;
    logic             idx_ok;
    logic             byte_ok;

    assign in_idx  = s_axis_tdata[7:0];
    assign in_word = s_axis_tdata[23:8];
    assign in_byte = s_axis_tdata[31:24];
    assign idx_ok  = {1'b0, in_idx} < 9'(PALETTE_DEPTH);
    assign byte_ok = {1'b0, in_byte} < 9'(PALETTE_DEPTH);

    assign s_axis_tready = i_q_ready && !r_hold;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_semi_on     = r_semi_on;

    always_comb begin
        o_push     = 1'b0;
        o_push_ent = '{op: OP_LOOKUP, addr: '0, word: '0, last: 1'b1};
        n_hold     = r_hold;
        if (r_hold) begin
            // Second pixel of a four-bit word: the high nibble.
            if (i_q_ready) begin
                o_push          = 1'b1;
                o_push_ent.addr = {4'b0000, r_hold_addr};
                n_hold          = 1'b0;
            end
        end else if (accept) begin
            if (!s_axis_tuser) begin
                o_push          = idx_ok;
                o_push_ent.op   = OP_LOAD;
                o_push_ent.addr = in_idx;
                o_push_ent.word = in_word;
            end else begin
                case (r_texel_mode)
                    MODE_4BPP: begin
                        o_push          = 1'b1;
                        o_push_ent.addr = {4'b0000, in_byte[3:0]};
                        o_push_ent.last = 1'b0;
                        n_hold          = 1'b1;
                    end
                    MODE_8BPP: begin
                        o_push          = 1'b1;
                        o_push_ent.op   = byte_ok ? OP_LOOKUP : OP_ZERO;
                        o_push_ent.addr = in_byte;
                    end
                    MODE_SOLID: begin
                        o_push        = 1'b1;
                        o_push_ent.op = OP_WHITE;
                    end
                    default: begin
                        o_push = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_texel_mode <= MODE_4BPP;
            r_semi_on    <= 1'b1;
            r_hold       <= 1'b0;
        end else begin
            r_hold <= n_hold;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IDX_MODE: r_texel_mode <= t_texel_mode'(i_cfg_wdata);
                    CFG_IDX_SEMI: r_semi_on    <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hold_addr <= in_byte[7:4];
        end
    end

endmodule

>>> sv/clttr_queue.sv
module clttr_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  clttr_pkg::t_qent i_ent,
    output logic             o_ready,
    output logic             o_valid,
    output clttr_pkg::t_qent o_ent,
    input  logic             i_pop
);

    import clttr_pkg::*;

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    t_qent          r_ent [DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [CW-1:0]  r_count;

    assign o_ready = r_count != CW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_ent   = r_ent[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wptr] <= i_ent;
        end
    end

endmodule

>>> sv/clttr_back.sv
module clttr_back #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  clttr_pkg::t_qent i_q_ent,
    output logic             o_q_pop,
    input  logic             i_semi_on,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [31:0]      m_axis_tdata,
    output logic             m_axis_tlast
);

    import clttr_pkg::*;

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic              r_s1_valid;
    t_op               r_s1_op;
    logic              r_s1_last;
    logic              r_out_valid;
    logic [31:0]       r_out_data;
    logic              r_out_last;

    logic              out_free;
    logic              s1_free;
    logic              ram_we;
    logic              ram_re;
    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] word;
    logic [4:0]        r5;
    logic [4:0]        g5;
    logic [4:0]        b5;
    logic              black;
    logic              mask;
    logic [7:0]        alpha;
    logic [31:0]       pixel;

    assign out_free = !r_out_valid || m_axis_tready;
    assign s1_free  = !r_s1_valid || out_free;
    assign o_q_pop  = i_q_valid && s1_free;
    assign ram_we   = o_q_pop && (i_q_ent.op == OP_LOAD);
    assign ram_re   = o_q_pop && (i_q_ent.op == OP_LOOKUP);

    clttr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_q_ent.addr[AW-1:0]),
        .i_wdata (i_q_ent.word),
        .i_re    (ram_re),
        .i_raddr (i_q_ent.addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        word  = (r_s1_op == OP_LOOKUP) ? ram_rdata : '0;
        r5    = word[4:0];
        g5    = word[9:5];
        b5    = word[14:10];
        mask  = word[15];
        black = (r5 | g5 | b5) == 5'd0;
        if (!mask && black) begin
            alpha = ALPHA_CLEAR;
        end else if (i_semi_on && mask && !black) begin
            alpha = ALPHA_SEMI;
        end else begin
            alpha = ALPHA_OPAQUE;
        end
        if (r_s1_op == OP_WHITE) begin
            pixel = {4{8'hff}};
        end else begin
            pixel = {alpha, f_expand5(b5), f_expand5(g5), f_expand5(r5)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= o_q_pop && (i_q_ent.op != OP_LOAD);
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_op   <= i_q_ent.op;
            r_s1_last <= i_q_ent.last;
        end
        if (r_s1_valid && out_free) begin
            r_out_data <= pixel;
            r_out_last <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

>>> sv/clut_texel_to_rgba_top.sv
// A word taken on the slave side passes the queue, the palette read stage and the output
// register before its pixel appears on the master side; the second pixel of a four-bit word follows it.
// Throughput: one word per cycle for loads, eight-bit and solid words unless the master side
// stalls; a four-bit word holds off the next until its high-nibble pixel is pushed. Palette reads use one RAM port.
// Reset (i_rst_n low at a clock edge) empties the pipeline and sets mode four-bit with
// semi-transparency on; palette contents are kept and undefined until written.
`include "clut_texel_to_rgba_top_assert.svh"

module clut_texel_to_rgba_top #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // palette_index[7:0], palette_word[23:8], texel_byte[31:24]
    input  logic        s_axis_tuser,  // cmd
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [1:0]  i_cfg_wdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    output logic        m_axis_tlast
);

    import clttr_pkg::*;

    logic  semi_on;
    logic  push;
    t_qent push_ent;
    logic  q_ready;
    logic  q_valid;
    t_qent q_ent;
    logic  q_pop;

    clttr_front #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_semi_on     (semi_on),
        .o_push        (push),
        .o_push_ent    (push_ent),
        .i_q_ready     (q_ready)
    );

    clttr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (push_ent),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_ent   (q_ent),
        .i_pop   (q_pop)
    );

    clttr_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_ent       (q_ent),
        .o_q_pop       (q_pop),
        .i_semi_on     (semi_on),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    `CLTTR_CHECK(a_push_has_room, push, q_ready)
    `CLTTR_CHECK(a_pop_has_entry, q_pop, q_valid)
    `CLTTR_CHECK(a_accept_needs_room, s_axis_tvalid && s_axis_tready, q_ready)
    `CLTTR_CHECK_NEXT(a_reset_empties_output, !i_rst_n, !m_axis_tvalid)

endmodule

>>> verif/tb_clut_texel_to_rgba_top.sv
`timescale 1ns / 100ps

module tb_clut_texel_to_rgba_top;
    import clttr_pkg::*;

    localparam int PAL_DEPTH   = 256;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 60;

    localparam bit CMD_LOAD  = 1'b0;
    localparam bit CMD_TEXEL = 1'b1;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } t_pixel;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;  // palette_index[7:0], palette_word[23:8], texel_byte[31:24]
    logic        s_axis_tuser = 1'b0;  // cmd
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [1:0]  i_cfg_wdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    logic        m_axis_tlast;

    logic [15:0] palette_copy [PAL_DEPTH];
    bit          palette_written [PAL_DEPTH];
    logic [1:0]  mode_reg = MODE_4BPP;
    logic        semi_reg = 1'b1;
    t_pixel      pixel_q [$];

    int errors = 0;
    int words_sent = 0;
    int loads_sent = 0;
    int pixels_seen = 0;
    int cycle_count = 0;
    bit src_idle_en = 1'b0;
    bit sink_idle_en = 1'b0;
    int hold_requests = 0;
    int hold_acked = 0;
    int hold_left = 0;
    int gap_left = 0;

    clut_texel_to_rgba_top #(
        .PALETTE_DEPTH(PAL_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run timed out with %0d pixels outstanding", $time, pixel_q.size());
            $display("tb_clut_texel_to_rgba_top NOT OK");
            $finish;
        end
    end

    function automatic logic [7:0] widen_channel(input logic [4:0] c);
        int v;
        v = (int'(c) * 255) / 31;
        return v[7:0];
    endfunction

    function automatic t_pixel colour_pixel(input logic [15:0] w, input logic last_flag);
        t_pixel p;
        logic black;
        black = (w[14:0] == 15'd0);
        p.red = widen_channel(w[4:0]);
        p.green = widen_channel(w[9:5]);
        p.blue = widen_channel(w[14:10]);
        if (!w[15] && black) begin
            p.alpha = ALPHA_CLEAR;
        end else if (semi_reg && w[15] && !black) begin
            p.alpha = ALPHA_SEMI;
        end else begin
            p.alpha = ALPHA_OPAQUE;
        end
        p.last = last_flag;
        return p;
    endfunction

    function automatic logic [15:0] palette_read(input int idx);
        if (idx < PAL_DEPTH) begin
            return palette_copy[8'(idx)];
        end
        return 16'h0000;
    endfunction

    task automatic queue_pixel(input t_pixel p);
        pixel_q = {pixel_q, p};
    endtask

    // Works out the pixels that one accepted word gives and queues them, or updates the palette copy for a load.
    task automatic predict_pixels(input bit cmd, input logic [7:0] idx,
                                  input logic [15:0] word, input logic [7:0] tbyte);
        t_pixel white;
        white = '{red: 8'hff, green: 8'hff, blue: 8'hff, alpha: ALPHA_OPAQUE, last: 1'b1};
        if (cmd == CMD_LOAD) begin
            if (int'(idx) < PAL_DEPTH) begin
                palette_copy[idx] = word;
                palette_written[idx] = 1'b1;
            end
        end else begin
            case (mode_reg)
                MODE_4BPP: begin
                    queue_pixel(colour_pixel(palette_read(int'(tbyte[3:0])), 1'b0));
                    queue_pixel(colour_pixel(palette_read(int'(tbyte[7:4])), 1'b1));
                end
                MODE_8BPP: begin
                    queue_pixel(colour_pixel(palette_read(int'(tbyte)), 1'b1));
                end
                MODE_SOLID: begin
                    queue_pixel(white);
                end
                default: begin
                end
            endcase
        end
    endtask

    task automatic send_word(input bit cmd, input logic [7:0] idx,
                             input logic [15:0] word, input logic [7:0] tbyte);
        int gap;
        @(negedge i_clk);
        if (src_idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {tbyte, word, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_pixels(cmd, idx, word, tbyte);
        words_sent++;
        if (cmd == CMD_LOAD) begin
            loads_sent++;
        end
    endtask

    task automatic send_load(input logic [7:0] idx, input logic [15:0] word);
        send_word(CMD_LOAD, idx, word, 8'($urandom));
    endtask

    task automatic send_texel(input logic [7:0] tbyte);
        send_word(CMD_TEXEL, 8'($urandom), 16'($urandom), tbyte);
    endtask

    // Lets the block run empty so that a register may be written safely.
    task automatic drain_block();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_IDX_MODE) begin
            mode_reg = value;
        end else begin
            semi_reg = value[0];
        end
    endtask

    function automatic logic [7:0] written_index(input int hi);
        int idx;
        idx = $urandom_range(0, hi);
        while (!palette_written[8'(idx)]) idx = $urandom_range(0, hi);
        return 8'(idx);
    endfunction

    // In four-bit and eight-bit modes, texel bytes only point at palette entries that hold a written colour.
    function automatic logic [7:0] pick_texel();
        logic [7:0] lo_idx;
        logic [7:0] hi_idx;
        case (mode_reg)
            MODE_4BPP: begin
                lo_idx = written_index(15);
                hi_idx = written_index(15);
                return {hi_idx[3:0], lo_idx[3:0]};
            end
            MODE_8BPP: return written_index(PAL_DEPTH - 1);
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_colour();
        case ($urandom_range(0, 7))
            0: return {1'($urandom), 15'h0000};
            1: return {1'($urandom), 15'h7fff};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_pixels
        t_pixel want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            pixels_seen++;
            if (pixel_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected pixel, expected none actual %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
            end else begin
                want = pixel_q.pop_front();
                report_field("red", int'(want.red), int'(m_axis_tdata[7:0]));
                report_field("green", int'(want.green), int'(m_axis_tdata[15:8]));
                report_field("blue", int'(want.blue), int'(m_axis_tdata[23:16]));
                report_field("alpha", int'(want.alpha), int'(m_axis_tdata[31:24]));
                report_field("last", int'(want.last), int'(m_axis_tlast));
            end
        end
    end

    // The receiver stalls in random bursts, and for one long stretch on request.
    always @(negedge i_clk) begin : sink_ready
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_acked != hold_requests) begin
            hold_acked++;
            hold_left = LONG_HOLD - 1;
            m_axis_tready <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left--;
            m_axis_tready <= 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(1, 8) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic test_directed();
        send_load(8'd0, 16'h0000);
        send_load(8'd1, 16'h8000);
        send_load(8'd2, 16'h7fff);
        send_load(8'd3, 16'hffff);
        send_load(8'd15, 16'h8421);
        send_load(8'd255, 16'h7c1f);
        send_load(8'd128, 16'h03e0);
        // Reset values of the registers: four-bit mode with semi-transparency on.
        send_texel(8'h10);
        send_texel(8'h32);
        send_texel(8'hf0);
        send_texel(8'h0f);
        send_texel(8'h3f);
        drain_block();
        write_reg(CFG_IDX_SEMI, 2'd0);
        send_texel(8'h33);
        send_texel(8'hf3);
        drain_block();
        write_reg(CFG_IDX_MODE, MODE_8BPP);
        send_texel(8'hff);
        send_texel(8'h80);
        send_texel(8'h00);
        send_texel(8'h03);
        drain_block();
        write_reg(CFG_IDX_MODE, MODE_SOLID);
        send_texel(8'ha5);
        send_texel(8'h00);
        drain_block();
        write_reg(CFG_IDX_MODE, MODE_UNUSED);
        send_texel(8'h5a);
        send_texel(8'hff);
        drain_block();
        write_reg(CFG_IDX_SEMI, 2'd1);
    endtask

    task automatic test_random_phases();
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        for (int p = 0; p < 12; p++) begin
            write_reg(CFG_IDX_MODE, 2'(p % 4));
            write_reg(CFG_IDX_SEMI, 2'((p >> 2) & 1));
            repeat (45) begin
                if ($urandom_range(0, 9) < 3) begin
                    if ($urandom_range(0, 1) == 0) begin
                        send_load(8'($urandom_range(0, 15)), pick_colour());
                    end else begin
                        send_load(8'($urandom), pick_colour());
                    end
                end else begin
                    send_texel(pick_texel());
                end
            end
            drain_block();
        end
    endtask

    task automatic test_backpressure();
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        write_reg(CFG_IDX_MODE, MODE_8BPP);
        hold_requests++;
        repeat (25) send_texel(pick_texel());
        drain_block();
        write_reg(CFG_IDX_MODE, MODE_4BPP);
        hold_requests++;
        repeat (15) send_texel(pick_texel());
        drain_block();
    endtask

    task automatic test_full_rate();
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        write_reg(CFG_IDX_SEMI, 2'd1);
        write_reg(CFG_IDX_MODE, MODE_4BPP);
        repeat (20) send_texel(pick_texel());
        drain_block();
        write_reg(CFG_IDX_MODE, MODE_8BPP);
        repeat (10) send_load(8'($urandom), pick_colour());
        repeat (20) send_texel(pick_texel());
        drain_block();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_phases();
        test_backpressure();
        test_full_rate();
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Sent %0d words (%0d palette loads) and checked %0d pixels,", words_sent,
                 loads_sent, pixels_seen);
        $display("covering every texel mode, both transparency settings and long stalls.");
        if (errors == 0) begin
            $display("tb_clut_texel_to_rgba_top OK");
        end else begin
            $display("tb_clut_texel_to_rgba_top NOT OK");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/clttr_pkg.sv
sv/clttr_ram.sv
sv/clttr_front.sv
sv/clttr_queue.sv
sv/clttr_back.sv
sv/clut_texel_to_rgba_top.sv
verif/tb_clut_texel_to_rgba_top.sv
